// ----- rtl/core/rbd_pkg.sv -----
// rbd_pkg: shared types and codes for the ring buffer deque
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SIZE       = 3'd4;
    localparam logic [OP_W-1:0] OP_EMPTY      = 3'd5;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd6;
    localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  result_value;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic cap_cmd;
        logic do_exec;
        logic cap_read;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        logic is_push;
        logic is_access;
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/core/rbd_ctrl.sv -----
// rbd_ctrl: command sequencer for the ring buffer deque
`timescale 1ns / 1ps
`default_nettype none

module rbd_ctrl
    import rbd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_ctrl      o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_push && !i_stat.full) begin
                    n_state = S_IDLE;
                end else if (i_stat.is_access && !i_stat.empty) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_ctrl.cap_cmd   = (r_state == S_IDLE) && i_in_valid;
    assign o_ctrl.do_exec   = (r_state == S_EXEC);
    assign o_ctrl.cap_read  = (r_state == S_READ);

endmodule

`default_nettype wire

// ----- rtl/core/rbd_datapath.sv -----
// rbd_datapath: slot memory, head and count registers and result register
`timescale 1ns / 1ps
`default_nettype none

module rbd_datapath
    import rbd_pkg::*;
#(
    parameter int unsigned DEPTH      = 1024,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire t_dp_ctrl i_ctrl,
    output t_dp_stat      o_stat,
    output t_out_item     o_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   L_DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] L_DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] L_LAST    = AW'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic [OP_W-1:0]       r_op;
    logic [DATA_WIDTH-1:0] r_word;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    t_out_item             r_res;

    logic [DATA_WIDTH-1:0] w_in_word;
    logic [VALUE_W-1:0]    w_rd_value;

    logic                  w_full;
    logic                  w_empty;
    logic [AW-1:0]         w_head_dec;
    logic [AW-1:0]         w_head_inc;
    logic [CW:0]           w_tail_sum;
    logic [CW:0]           w_back_sum;
    logic [AW-1:0]         w_tail;
    logic [AW-1:0]         w_back;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [AW-1:0]         n_head;
    logic [CW-1:0]         n_count;
    logic                  w_res_load;
    t_out_item             n_res;

    generate
        if (DATA_WIDTH <= VALUE_W) begin : g_narrow
            assign w_in_word  = i_item.push_value[DATA_WIDTH-1:0];
            assign w_rd_value = VALUE_W'(r_rd_data);
        end else begin : g_wide
            assign w_in_word  = DATA_WIDTH'(i_item.push_value);
            assign w_rd_value = r_rd_data[VALUE_W-1:0];
        end
    endgenerate

    assign w_full     = (r_count == L_DEPTH_C);
    assign w_empty    = (r_count == '0);
    assign w_head_dec = (r_head == '0) ? L_LAST : r_head - AW'(1);
    assign w_head_inc = (r_head == L_LAST) ? '0 : r_head + AW'(1);
    assign w_tail_sum = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign w_back_sum = w_tail_sum - (CW + 1)'(1);
    assign w_tail     = (w_tail_sum >= L_DEPTH_S) ? AW'(w_tail_sum - L_DEPTH_S)
                                                  : AW'(w_tail_sum);
    assign w_back     = (w_back_sum >= L_DEPTH_S) ? AW'(w_back_sum - L_DEPTH_S)
                                                  : AW'(w_back_sum);

    always_comb begin
        w_we       = 1'b0;
        w_waddr    = r_head;
        w_re       = 1'b0;
        w_raddr    = r_head;
        n_head     = r_head;
        n_count    = r_count;
        w_res_load = 1'b0;
        n_res      = '{result_value: '0, status: ST_OK};
        if (i_ctrl.do_exec) begin
            case (r_op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (w_full) begin
                        w_res_load = 1'b1;
                        n_res      = '{result_value: '0, status: ST_FULL};
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + CW'(1);
                        if (r_op == OP_PUSH_FRONT) begin
                            w_waddr = w_head_dec;
                            n_head  = w_head_dec;
                        end else begin
                            w_waddr = w_tail;
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                    if (w_empty) begin
                        w_res_load = 1'b1;
                        n_res      = '{result_value: '0, status: ST_EMPTY};
                    end else begin
                        w_re = 1'b1;
                        if (r_op == OP_POP_BACK || r_op == OP_PEEK_BACK) begin
                            w_raddr = w_back;
                        end
                        if (r_op == OP_POP_FRONT) begin
                            n_head  = w_head_inc;
                            n_count = r_count - CW'(1);
                        end else if (r_op == OP_POP_BACK) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
                OP_SIZE: begin
                    w_res_load = 1'b1;
                    n_res      = '{result_value: VALUE_W'(r_count), status: ST_OK};
                end
                default: begin
                    w_res_load = 1'b1;
                    n_res      = '{result_value: VALUE_W'(w_empty), status: ST_OK};
                end
            endcase
        end else if (i_ctrl.cap_read) begin
            w_res_load = 1'b1;
            n_res      = '{result_value: w_rd_value, status: ST_OK};
        end
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap_cmd) begin
            r_op   <= i_item.op;
            r_word <= w_in_word;
        end
        if (w_res_load) begin
            r_res <= n_res;
        end
    end

    assign o_stat.is_push   = (r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_BACK);
    assign o_stat.is_access = (r_op == OP_POP_FRONT) || (r_op == OP_POP_BACK)
                           || (r_op == OP_PEEK_FRONT) || (r_op == OP_PEEK_BACK);
    assign o_stat.full      = w_full;
    assign o_stat.empty     = w_empty;
    assign o_item           = r_res;

endmodule

`default_nettype wire

// ----- rtl/core/ring_buffer_deque_core.sv -----
// ring_buffer_deque_core: top level of the ring buffer deque
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of DEPTH words held in a single-port-per-direction slot
// memory with a wrapping head pointer and an element count. One command is
// taken at a time: a successful push goes from execute back to ready; size,
// empty and any command refused for a full or empty queue go from execute
// to the result state; a pop or peek passes through a read state for the
// registered memory read first. The next command is taken once the result
// has been transferred out. Pushes that succeed give no result.

module ring_buffer_deque_core
    import rbd_pkg::*;
#(
    parameter int unsigned DEPTH      = 1024,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    rbd_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

// ----- rtl/core/rbd_checker.sv -----
// rbd_checker: port-level assertions for the ring buffer deque
`timescale 1ns / 1ps
`default_nettype none

module rbd_checker
    import rbd_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_ready,
    input wire t_in_item  i_item,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_item o_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_item)))
        else $error("result changed before transfer");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("command taken while a result is pending");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (!o_ready && !o_valid))
        else $error("not busy after command transfer");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> !o_valid)
        else $error("more than one result for a command");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.status == ST_OK || o_item.status == ST_EMPTY
                     || (o_item.status == ST_FULL && o_item.result_value == '0)))
        else $error("bad status code");

endmodule

bind ring_buffer_deque_core rbd_checker u_rbd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

`default_nettype wire

// ----- tb/sv/deque_checker.sv -----
// deque_checker: predicts and checks results on the ring buffer deque channels
`timescale 1ns / 1ps

module deque_checker
    import rbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  logic      i_cmd_ready,
    input  t_in_item  i_cmd,
    input  logic      i_res_valid,
    input  logic      i_res_ready,
    input  t_out_item i_res,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int unsigned SLOT_COUNT = 1024;

    logic [VALUE_W-1:0] slot_mem [SLOT_COUNT];
    logic [9:0]         head_idx;
    logic [10:0]        live_count;
    t_out_item          expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        head_idx     = '0;
        live_count   = '0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t deque_checker: %s got %h want %h", $time, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    // advances the deque by one command, gives the result it returns if any
    task automatic apply_deque_cmd(input t_in_item cmd, output bit has_result,
                                   output t_out_item result);
        logic [9:0] idx;
        has_result = 1'b1;
        result     = '{result_value: '0, status: ST_OK};
        case (cmd.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (live_count == 11'(SLOT_COUNT)) begin
                    result.status = ST_FULL;
                end else begin
                    if (cmd.op == OP_PUSH_FRONT) begin
                        head_idx = head_idx - 10'd1;
                        idx      = head_idx;
                    end else begin
                        idx = head_idx + live_count[9:0];
                    end
                    slot_mem[idx] = cmd.push_value;
                    live_count    = live_count + 11'd1;
                    has_result    = 1'b0;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (live_count == '0) begin
                    result.status = ST_EMPTY;
                end else begin
                    if (cmd.op == OP_POP_FRONT || cmd.op == OP_PEEK_FRONT) begin
                        idx = head_idx;
                    end else begin
                        idx = head_idx + live_count[9:0] - 10'd1;
                    end
                    result.result_value = slot_mem[idx];
                    if (cmd.op == OP_POP_FRONT) begin
                        head_idx   = head_idx + 10'd1;
                        live_count = live_count - 11'd1;
                    end else if (cmd.op == OP_POP_BACK) begin
                        live_count = live_count - 11'd1;
                    end
                end
            end
            OP_SIZE: begin
                result.result_value = VALUE_W'(live_count);
            end
            default: begin
                result.result_value = (live_count == '0) ? VALUE_W'(1) : '0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin : track
        t_out_item want;
        bit        has_result;
        if (!i_rst_n) begin
            head_idx   = '0;
            live_count = '0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected, value", i_res.result_value,
                                    '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.result_value !== want.result_value) begin
                        report_mismatch("result_value", i_res.result_value, want.result_value);
                    end
                    if (i_res.status !== want.status) begin
                        report_mismatch("status", 32'(i_res.status), 32'(want.status));
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                apply_deque_cmd(i_cmd, has_result, want);
                if (has_result) begin
                    expected_results.push_back(want);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- tb/sv/ring_buffer_deque_core_test.sv -----
// ring_buffer_deque_core_test: stimulus and verdict for the ring buffer deque core
`timescale 1ns / 1ps

module ring_buffer_deque_core_test;
    import rbd_pkg::*;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      cmd_valid    = 1'b0;
    logic      cmd_ready;
    t_in_item  cmd_item     = '0;
    logic      res_valid;
    logic      res_ready    = 1'b0;
    t_out_item res_item;
    bit        cmd_idle_on  = 1'b1;
    bit        res_stall_on = 1'b1;
    int        fail_count;
    int        pending;

    always #4 clk = ~clk;

    ring_buffer_deque_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (cmd_valid),
        .o_ready (cmd_ready),
        .i_item  (cmd_item),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_item  (res_item)
    );

    deque_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .i_cmd        (cmd_item),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res        (res_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        res_ready <= !res_stall_on || ($urandom_range(0, 99) >= 26);
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        while (cmd_idle_on && $urandom_range(0, 99) < 26) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= '{op: op, push_value: value};
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
    endtask

    // weighted pick: pushes, then pops, the rest spread over peeks, size and empty
    function automatic logic [OP_W-1:0] pick_op(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else if (roll < push_pct + pop_pct) begin
            return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        end
        case ($urandom_range(0, 3))
            0: return OP_PEEK_FRONT;
            1: return OP_PEEK_BACK;
            2: return OP_SIZE;
            default: return OP_EMPTY;
        endcase
    endfunction

    initial begin
        #5ms;
        $display("ring_buffer_deque_core_test: FAIL");
        $finish;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue refusals and reports
        send_cmd(OP_POP_FRONT, 32'h1234_5678);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_PEEK_FRONT, 32'hFFFF_FFFF);
        send_cmd(OP_PEEK_BACK, 32'h0);
        send_cmd(OP_SIZE, 32'h0);
        send_cmd(OP_EMPTY, 32'h0);
        // head wraps below slot zero on the first front push
        send_cmd(OP_PUSH_FRONT, 32'h0000_0000);
        send_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_cmd(OP_PUSH_FRONT, 32'hA5A5_5A5A);
        send_cmd(OP_PUSH_BACK, 32'h5A5A_A5A5);
        send_cmd(OP_PEEK_FRONT, 32'h0);
        send_cmd(OP_PEEK_BACK, 32'h0);
        send_cmd(OP_SIZE, 32'hFFFF_FFFF);
        send_cmd(OP_EMPTY, 32'hFFFF_FFFF);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_POP_FRONT, 32'h0);
        send_cmd(OP_POP_FRONT, 32'h0);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_SIZE, 32'h0);
        send_cmd(OP_EMPTY, 32'h0);
        // single element seen from both ends
        send_cmd(OP_PUSH_FRONT, 32'h8000_0001);
        send_cmd(OP_PEEK_BACK, 32'h0);
        send_cmd(OP_POP_BACK, 32'h0);
        send_cmd(OP_POP_FRONT, 32'h0);

        repeat (250) send_cmd(pick_op(45, 30), $urandom());

        // long push run with no idling, then mixed work
        cmd_idle_on  = 1'b0;
        res_stall_on = 1'b0;
        repeat (150) send_cmd(pick_op(100, 0), $urandom());
        cmd_idle_on  = 1'b1;
        res_stall_on = 1'b1;
        repeat (20) send_cmd(pick_op(0, 0), $urandom());
        repeat (80) send_cmd(pick_op(50, 50), $urandom());

        // drain past empty
        repeat (250) send_cmd(pick_op(0, 100), $urandom());

        cmd_idle_on  = 1'b0;
        res_stall_on = 1'b0;
        repeat (100) send_cmd(pick_op(45, 30), $urandom());
        cmd_idle_on  = 1'b1;
        res_stall_on = 1'b1;
        repeat (80) send_cmd(pick_op(45, 30), $urandom());
        cmd_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ring_buffer_deque_core_test: PASS");
        end else begin
            $display("ring_buffer_deque_core_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rbd_pkg.sv
rtl/core/rbd_ctrl.sv
rtl/core/rbd_datapath.sv
rtl/core/ring_buffer_deque_core.sv
rtl/core/rbd_checker.sv
tb/sv/deque_checker.sv
tb/sv/ring_buffer_deque_core_test.sv
